[hw/rtl/bra_pkg.sv]
// Package for the bitmap run allocator: sizes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package bra_pkg;
  localparam int WordBits    = 64;
  localparam int MapEntries  = 4096;
  localparam int ByteEntries = 8;
  localparam int SliceBits   = 8;
  localparam logic [9:0] MapBytesReset = 10'd512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK,
    ST_FREE_RD,
    ST_FREE,
    ST_DONE
  } state_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the request, reset scan state
    logic fetch;    // register the bitmap word at the current index
    logic scan;     // examine current slice of the fetched word
    logic mark;     // set bits of found run in the fetched word
    logic clr;      // clear bits of a free in the fetched word
    logic respond;  // drive the result strobe
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic alloc_bad;   // zero count or larger than map
    logic found;       // run completed in this slice
    logic slice_last;  // this slice is the last of its word
    logic scan_last;   // this scan word is the last below the map end
    logic mark_last;   // final word of mark
    logic clr_last;    // final word of free
  } stat_t;
endpackage

[hw/rtl/bra_ctrl.sv]
// Controller state machine of the bitmap run allocator.
// Depends on bra_pkg.
module bra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           action,
  input  bra_pkg::stat_t stat,
  output bra_pkg::cmd_t  cmd,
  output logic           busy
);
  bra_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bra_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bra_pkg::ST_IDLE: if (start) begin
        state_next = (action == bra_pkg::ACT_FREE) ? bra_pkg::ST_FREE_RD
                                                   : bra_pkg::ST_SCAN_RD;
      end
      bra_pkg::ST_SCAN_RD: begin
        state_next = stat.alloc_bad ? bra_pkg::ST_DONE : bra_pkg::ST_SCAN;
      end
      bra_pkg::ST_SCAN: begin
        if (stat.found) state_next = bra_pkg::ST_MARK_RD;
        else if (stat.slice_last) begin
          state_next = stat.scan_last ? bra_pkg::ST_DONE : bra_pkg::ST_SCAN_RD;
        end
      end
      bra_pkg::ST_MARK_RD: state_next = bra_pkg::ST_MARK;
      bra_pkg::ST_MARK: begin
        state_next = stat.mark_last ? bra_pkg::ST_DONE : bra_pkg::ST_MARK_RD;
      end
      bra_pkg::ST_FREE_RD: state_next = bra_pkg::ST_FREE;
      bra_pkg::ST_FREE: begin
        state_next = stat.clr_last ? bra_pkg::ST_DONE : bra_pkg::ST_FREE_RD;
      end
      bra_pkg::ST_DONE: state_next = bra_pkg::ST_IDLE;
      default: state_next = bra_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      bra_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      bra_pkg::ST_SCAN_RD: cmd.fetch = !stat.alloc_bad;
      bra_pkg::ST_SCAN:    cmd.scan = 1'b1;
      bra_pkg::ST_MARK_RD: cmd.fetch = 1'b1;
      bra_pkg::ST_MARK:    cmd.mark = 1'b1;
      bra_pkg::ST_FREE_RD: cmd.fetch = 1'b1;
      bra_pkg::ST_FREE:    cmd.clr = 1'b1;
      bra_pkg::ST_DONE:    cmd.respond = 1'b1;
      default: busy = 1'b1;
    endcase
  end

`ifndef SYNTH
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.fetch, cmd.scan, cmd.mark, cmd.clr, cmd.respond}))
    else $error("multiple datapath commands");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accept");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> !busy)
    else $error("not idle after result");
`endif
endmodule

[hw/rtl/bra_dp.sv]
// Datapath of the bitmap run allocator: bitmap memory, slice scan, mark and
// clear sweeps, result registers. Depends on bra_pkg.
module bra_dp #(
  parameter int WORD_BITS   = bra_pkg::WordBits,
  parameter int MAP_ENTRIES = bra_pkg::MapEntries
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [9:0]                    cfg_data,
  input  logic                          action,
  input  logic [11:0]                   start_entry,
  input  logic [12:0]                   count,
  input  bra_pkg::cmd_t                 cmd,
  output bra_pkg::stat_t                stat,
  output logic                          done,
  output logic                          ok,
  output logic [11:0]                   run_start,
  output logic [12:0]                   longest_run
);
  localparam int NumWords = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int EW = $clog2(MAP_ENTRIES + 1);
  localparam int CW = 14;
  localparam int SB = bra_pkg::SliceBits;
  localparam int NumSlices = WORD_BITS / SB;
  localparam int SW = (NumSlices > 1) ? $clog2(NumSlices) : 1;

  // bitmap with one valid bit per word (reset clears to free)
  logic [WORD_BITS-1:0] mem [NumWords];
  logic [NumWords-1:0]  vld;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_v;
  logic [9:0]           map_bytes;
  logic [EW-1:0]        total;
  logic [13:0]          tot_raw;

  always_ff @(posedge clk) begin
    if (rst) map_bytes <= bra_pkg::MapBytesReset;
    else if (cfg_we) map_bytes <= cfg_data;
  end
  assign tot_raw = {1'b0, map_bytes, 3'b000};
  always_comb begin
    if (32'(tot_raw) > 32'(MAP_ENTRIES)) total = EW'(MAP_ENTRIES);
    else total = EW'(tot_raw);
  end

  // request registers
  logic [CW-1:0] req_cnt;
  logic [EW:0]   lo, hi;    // current range [lo,hi) for mark / clear
  logic [AW-1:0] widx;
  logic [SW-1:0] sidx;
  logic          bad;
  logic [CW-1:0] run, longest;
  logic [EW:0]   first;
  logic          ok_r;
  logic          alloc_ok;

  // fetched word, gated by its valid bit
  logic [WORD_BITS-1:0] rd;
  assign rd = rd_v ? rd_q : '0;

  // word and slice base entries
  logic [EW:0]   base, sbase;
  logic [SB-1:0] slice;
  logic          slice_last;
  assign base = (EW+1)'(widx) * (EW+1)'(WORD_BITS);
  assign sbase = base + (EW+1)'(32'(sidx) * SB);
  assign slice = rd[32'(sidx) * SB +: SB];
  assign slice_last = (32'(sidx) == NumSlices - 1);

  // scan one slice: bits at or past total count as used
  logic [CW-1:0] r_run, r_long;
  logic [EW:0]   r_first;
  logic          r_found;
  logic [EW:0]   r_end;
  always_comb begin
    logic u;
    logic [EW:0] e;
    r_run = run; r_long = longest; r_first = first; r_found = 1'b0; r_end = '0;
    for (int b = 0; b < SB; b++) begin
      e = sbase + (EW+1)'(b);
      u = slice[b] || (e >= (EW+1)'(total));
      if (!r_found) begin
        if (u) begin
          r_run = '0;
          r_first = e + 1'b1;
        end else begin
          r_run = r_run + 1'b1;
          if (r_run > r_long) r_long = r_run;
          if (r_run == req_cnt) begin
            r_found = 1'b1;
            r_end = e + 1'b1;
          end
        end
      end
    end
  end

  // range masks for the current word
  logic [WORD_BITS-1:0] rmask;
  always_comb begin
    logic [EW:0] e;
    for (int b = 0; b < WORD_BITS; b++) begin
      e = base + (EW+1)'(b);
      rmask[b] = (e >= lo) && (e < hi);
    end
  end

  logic [EW:0] hi_last;
  assign hi_last = hi - 1'b1;
  assign stat.alloc_bad  = bad;
  assign stat.found      = r_found;
  assign stat.slice_last = slice_last;
  assign stat.scan_last  = (base + (EW+1)'(WORD_BITS)) >= (EW+1)'(total);
  assign stat.mark_last  = (hi_last[EW:BW] == (EW+1-BW)'(widx)) || (lo >= hi);
  assign stat.clr_last   = stat.mark_last;

  logic [EW+1:0] fend;
  assign fend = (EW+2)'(start_entry) + (EW+2)'(count);

  // bitmap word read and write-back
  always_ff @(posedge clk) begin
    if (cmd.fetch) rd_q <= mem[widx];
    if (cmd.mark)     mem[widx] <= rd | rmask;
    else if (cmd.clr) mem[widx] <= rd & ~rmask;
  end

  // valid bits, result strobe and request state
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_v <= 1'b0;
      done <= 1'b0;
      alloc_ok <= 1'b0;
    end else begin
      done <= cmd.respond;
      if (cmd.fetch) rd_v <= vld[widx];
      if (cmd.load) begin
        req_cnt <= CW'(count);
        bad <= (count == '0) || (32'(count) > 32'(total));
        run <= '0; longest <= '0; first <= '0; ok_r <= 1'b0; alloc_ok <= 1'b0;
        sidx <= '0;
        lo <= (EW+1)'(start_entry);
        hi <= (32'(fend) > 32'(total)) ? (EW+1)'(total) : (EW+1)'(fend);
        // allocate scans from entry zero; free starts at its first word
        if (action == bra_pkg::ACT_ALLOC || 32'(start_entry) >= 32'(total)) begin
          widx <= '0;
        end else begin
          widx <= AW'(start_entry >> BW);
        end
      end
      if (cmd.scan) begin
        run <= r_run; longest <= r_long; first <= r_first;
        if (r_found) begin
          ok_r <= 1'b1;
          alloc_ok <= 1'b1;
          lo <= r_first; hi <= r_end;
          widx <= AW'(r_first >> BW);
          sidx <= '0;
        end else if (slice_last) begin
          widx <= widx + 1'b1;
          sidx <= '0;
        end else begin
          sidx <= sidx + 1'b1;
        end
      end
      if (cmd.mark || cmd.clr) begin
        vld[widx] <= 1'b1;
        widx <= widx + 1'b1;
        if (cmd.clr) ok_r <= 1'b1;
      end
    end
  end

  assign ok = ok_r;
  assign run_start = alloc_ok ? 12'(first) : 12'd0;
  assign longest_run = (longest > CW'(13'h1FFF)) ? 13'h1FFF : 13'(longest);

`ifndef SYNTH
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.scan && r_found |=> ok_r)
    else $error("run found but ok not set");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.mark || cmd.clr) |-> 32'(widx) < NumWords)
    else $error("sweep index out of range");
  a_resp_one: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done, 2))
    else $error("double result");
`endif
endmodule

[hw/rtl/bitmap_run_allocator.sv]
// Top level of the bitmap run allocator: controller plus datapath.
// Depends on bra_pkg, bra_ctrl, bra_dp.
//
// channel  | signals                          | handshake
// config   | map_bytes_we, map_bytes          | written when we high
// request  | action, start_entry, count       | start high, busy low
// result   | ok, run_start, longest_run       | done strobe, one cycle
//
// Allocate: each map word scanned, at most to the map end, is read, then
// examined in 8-bit slices; each word of the found run is read and written
// back; then the result. Free: each word touched is read and written back,
// then the result. Zero or oversize allocate: a read step, then the result.
// done strobes the cycle after; a new request is taken in that same cycle.
// Reset clears the map at once via per-word valid bits. Receiver cannot stall.
module bitmap_run_allocator #(
  parameter int WORD_BITS   = bra_pkg::WordBits,
  parameter int MAP_ENTRIES = bra_pkg::MapEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        map_bytes_we,
  input  logic [9:0]  map_bytes,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [11:0] start_entry,
  input  logic [12:0] count,
  output logic        done,
  output logic        ok,
  output logic [11:0] run_start,
  output logic [12:0] longest_run
);
  bra_pkg::cmd_t  cmd;
  bra_pkg::stat_t stat;

  bra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  bra_dp #(.WORD_BITS(WORD_BITS), .MAP_ENTRIES(MAP_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(map_bytes_we), .cfg_data(map_bytes),
    .action(action), .start_entry(start_entry), .count(count), .cmd(cmd),
    .stat(stat), .done(done), .ok(ok), .run_start(run_start),
    .longest_run(longest_run)
  );
endmodule
